>>> rtl/i2r_pkg.sv
package i2r_pkg;

    localparam int NUM_W  = 12;
    localparam int CHAR_W = 7;

    localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(3999);

    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_M    = 7'h4D;
    localparam logic [CHAR_W-1:0] CHAR_D    = 7'h44;
    localparam logic [CHAR_W-1:0] CHAR_C    = 7'h43;
    localparam logic [CHAR_W-1:0] CHAR_L    = 7'h4C;
    localparam logic [CHAR_W-1:0] CHAR_X    = 7'h58;
    localparam logic [CHAR_W-1:0] CHAR_V    = 7'h56;
    localparam logic [CHAR_W-1:0] CHAR_I    = 7'h49;

    typedef struct packed {
        logic [NUM_W-1:0]  value;
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
        logic              two;
    } t_tok;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_sts;

    function automatic t_tok mk_tok(input int val, input logic [CHAR_W-1:0] c1,
                                    input logic [CHAR_W-1:0] c2, input logic two);
        t_tok t;
        t.value  = NUM_W'(val);
        t.first  = c1;
        t.second = c2;
        t.two    = two;
        return t;
    endfunction

    // largest roman token not above the remainder
    function automatic t_tok tok_lookup(input logic [NUM_W-1:0] rem);
        t_tok t;
        priority if (rem >= NUM_W'(1000)) t = mk_tok(1000, CHAR_M, CHAR_NONE, 1'b0);
        else if (rem >= NUM_W'(900))      t = mk_tok(900,  CHAR_C, CHAR_M,    1'b1);
        else if (rem >= NUM_W'(500))      t = mk_tok(500,  CHAR_D, CHAR_NONE, 1'b0);
        else if (rem >= NUM_W'(400))      t = mk_tok(400,  CHAR_C, CHAR_D,    1'b1);
        else if (rem >= NUM_W'(100))      t = mk_tok(100,  CHAR_C, CHAR_NONE, 1'b0);
        else if (rem >= NUM_W'(90))       t = mk_tok(90,   CHAR_X, CHAR_C,    1'b1);
        else if (rem >= NUM_W'(50))       t = mk_tok(50,   CHAR_L, CHAR_NONE, 1'b0);
        else if (rem >= NUM_W'(40))       t = mk_tok(40,   CHAR_X, CHAR_L,    1'b1);
        else if (rem >= NUM_W'(10))       t = mk_tok(10,   CHAR_X, CHAR_NONE, 1'b0);
        else if (rem >= NUM_W'(9))        t = mk_tok(9,    CHAR_I, CHAR_X,    1'b1);
        else if (rem >= NUM_W'(5))        t = mk_tok(5,    CHAR_V, CHAR_NONE, 1'b0);
        else if (rem >= NUM_W'(4))        t = mk_tok(4,    CHAR_I, CHAR_V,    1'b1);
        else                              t = mk_tok(1,    CHAR_I, CHAR_NONE, 1'b0);
        return t;
    endfunction

endpackage

>>> rtl/i2r_ctrl.sv
module i2r_ctrl
    import i2r_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.step = (r_state == ST_RUN) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (o_cmd.step && i_sts.last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_RUN)
        else $error("load did not start a run");

    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> i_sts.out_free && !o_cmd.load)
        else $error("step issued without output room");

endmodule

>>> rtl/i2r_dp.sv
module i2r_dp
    import i2r_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NUM_W-1:0]  i_number,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last,
    output logic              o_out_err
);

    logic [NUM_W-1:0]  r_rem, n_rem;
    logic              r_err;
    logic              r_pend, n_pend;
    logic [CHAR_W-1:0] r_second, n_second;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_char;
    logic              r_out_last, n_last;
    logic              r_out_err;
    t_tok              tok;

    always_comb begin
        tok      = tok_lookup(r_rem);
        n_rem    = r_rem;
        n_pend   = r_pend;
        n_second = r_second;
        n_char   = CHAR_NONE;
        n_last   = 1'b1;
        if (r_err) begin
            n_char = CHAR_NONE;
            n_last = 1'b1;
        end else if (r_pend) begin
            n_char = r_second;
            n_pend = 1'b0;
            n_last = (r_rem == '0);
        end else begin
            n_char   = tok.first;
            n_rem    = r_rem - tok.value;
            n_pend   = tok.two;
            n_second = tok.second;
            n_last   = !tok.two && (n_rem == '0);
        end
        o_sts.last     = n_last;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else if (i_cmd.step) begin
                r_pend <= n_pend;
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_number;
            r_err <= (i_number == '0) || (i_number > NUM_MAX);
        end else if (i_cmd.step) begin
            r_rem    <= n_rem;
            r_second <= n_second;
        end
        if (i_cmd.step) begin
            r_out_char <= n_char;
            r_out_last <= n_last;
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_out_err   = r_out_err;

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_last && r_out_char == CHAR_NONE)
        else $error("error beat malformed");

    a_pend_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && r_pend |=> !r_pend)
        else $error("pending letter not drained");

endmodule

>>> rtl/integer_to_roman_encoder_top.sv
// channel  | dir | tdata               | tlast    | tuser
// s_axis   | in  | [11:0] number       | -        | -
// m_axis   | out | [6:0] char_code     | is_last  | out_of_range
//
// a number giving n letters yields n beats, at most 15 (3888); an error
// result is one beat. after the load, one letter per cycle while m_axis is
// free comes from the token compare/subtract on the remainder. the output
// register lets the next number load while the final beat waits. synchronous
// active-low reset; a stalled m_axis holds the walk without losing letters.
module integer_to_roman_encoder_top
    import i2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] char_code
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] out_of_range
);

    t_cmd              cmd;
    t_sts              sts;
    logic [CHAR_W-1:0] out_char;

    i2r_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    i2r_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_number    (s_axis_tdata[NUM_W-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (out_char),
        .o_out_last  (m_axis_tlast),
        .o_out_err   (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule
